// File: rtl/core/tcp_pkg.sv
// ---------------------------------------------------------------------------
// tcp_pkg
// shared constants, types and helper functions of the tuning command parser
// ---------------------------------------------------------------------------
`default_nettype none

package tcp_pkg;

    localparam int unsigned POS_W         = 8;
    localparam int unsigned MAX_FRAME_DEF = 200;
    localparam int unsigned TAIL_D        = 10;
    localparam int unsigned DIG_N         = 9;
    localparam int unsigned TGT_W         = 4;
    localparam int unsigned PART_W        = 19;
    localparam int unsigned VAL_W         = 33;
    localparam int unsigned SUM_W         = 34;
    localparam int unsigned IN_TDATA_W    = 8;
    localparam int unsigned OUT_TDATA_W   = 40;

    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef logic [TGT_W-1:0] t_target;

    localparam t_target TGT_NONE = 4'd0;
    localparam t_target TGT_P1   = 4'd1;
    localparam t_target TGT_I1   = 4'd2;
    localparam t_target TGT_D1   = 4'd3;
    localparam t_target TGT_SPE  = 4'd4;
    localparam t_target TGT_P2   = 4'd5;
    localparam t_target TGT_I2   = 4'd6;
    localparam t_target TGT_D2   = 4'd7;
    localparam t_target TGT_POS  = 4'd8;
    localparam t_target TGT_RES  = 4'd9;

    // frame snapshot taken when the end marker arrives
    typedef struct packed {
        t_target                  target;
        logic                     ok;
        logic                     neg;
        logic [2:0]               int_cnt;
        logic [DIG_N-1:0][7:0]    tail;
    } t_frm;

    function automatic t_target decode_target(input logic [2:0][7:0] h);
        t_target t;
        t = TGT_NONE;
        if      (h[0] == "P" && h[1] == "1")                 t = TGT_P1;
        else if (h[0] == "I" && h[1] == "1")                 t = TGT_I1;
        else if (h[0] == "D" && h[1] == "1")                 t = TGT_D1;
        else if (h[0] == "S" && h[1] == "p" && h[2] == "e")  t = TGT_SPE;
        else if (h[0] == "P" && h[1] == "2")                 t = TGT_P2;
        else if (h[0] == "I" && h[1] == "2")                 t = TGT_I2;
        else if (h[0] == "D" && h[1] == "2")                 t = TGT_D2;
        else if (h[0] == "P" && h[1] == "o" && h[2] == "s")  t = TGT_POS;
        else if (h[0] == "R" && h[1] == "E" && h[2] == "S")  t = TGT_RES;
        return t;
    endfunction

    function automatic logic signed [PART_W-1:0] pow10(input logic [1:0] e);
        logic signed [PART_W-1:0] w;
        case (e)
            2'd0:    w = 19'sd1;
            2'd1:    w = 19'sd10;
            2'd2:    w = 19'sd100;
            2'd3:    w = 19'sd1000;
            default: w = 19'sd1;
        endcase
        return w;
    endfunction

    // byte taken as a digit: byte minus ascii zero, range -48..207
    function automatic logic signed [PART_W-1:0] digit(input logic [7:0] b);
        logic [8:0] d;
        d = {1'b0, b} - {1'b0, CH_ZERO};
        return PART_W'($signed(d));
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/tcp_frame_track.sv
// ---------------------------------------------------------------------------
// tcp_frame_track
// frame position, head bytes, tail window and value start; snapshots a frame
// into a register when the end marker is accepted
// ---------------------------------------------------------------------------
`default_nettype none

module tcp_frame_track #(
    parameter int unsigned MAX_FRAME = tcp_pkg::MAX_FRAME_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_byte,
    output logic               o_valid,
    input  wire logic          i_ready,
    output tcp_pkg::t_frm      o_frm
);

    localparam logic [tcp_pkg::POS_W-1:0] POS_MAX = tcp_pkg::POS_W'(MAX_FRAME);

    logic [tcp_pkg::POS_W-1:0]              r_pos, n_pos;
    logic [tcp_pkg::POS_W-1:0]              r_start, n_start;
    logic [2:0][7:0]                        r_head, n_head;
    logic [tcp_pkg::TAIL_D-1:0][7:0]        r_tail, n_tail;
    logic                                   r_valid;
    tcp_pkg::t_frm                          r_frm;

    logic                                   take;
    logic                                   is_bang;
    logic                                   in_frame;
    logic [2:0][7:0]                        head_upd;
    logic [tcp_pkg::POS_W-1:0]              span;
    logic [tcp_pkg::POS_W-1:0]              span_m1;
    logic [tcp_pkg::POS_W-1:0]              n_len;
    logic [tcp_pkg::POS_W-1:0]              len_m5;
    logic                                   span_ok;
    logic [7:0]                             first;
    tcp_pkg::t_frm                          frm;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign is_bang = (i_byte == tcp_pkg::CH_BANG);
    assign in_frame = (r_pos < POS_MAX);

    always_comb begin
        head_upd = r_head;
        if (r_pos < 8'd3) begin
            head_upd[r_pos[1:0]] = i_byte;
        end
        span    = r_pos - r_start;
        span_m1 = span - 8'd1;
        span_ok = in_frame && (span != 8'd0) && (span <= 8'(tcp_pkg::TAIL_D));
        first   = span_ok ? r_tail[span_m1[3:0]] : 8'd0;
        frm.neg = span_ok && (first == tcp_pkg::CH_MINUS);
        n_len   = frm.neg ? span_m1 : span;
        len_m5  = n_len - 8'd5;
        frm.ok  = span_ok && (n_len >= 8'd6) && (n_len <= 8'd9);
        frm.int_cnt = len_m5[2:0];
        frm.target  = tcp_pkg::decode_target(head_upd);
        frm.tail    = r_tail[tcp_pkg::DIG_N-1:0];
    end

    always_comb begin
        n_pos   = r_pos;
        n_start = r_start;
        n_head  = r_head;
        n_tail  = r_tail;
        if (take) begin
            if (is_bang) begin
                n_pos   = '0;
                n_start = '0;
                n_head  = '0;
                n_tail  = '0;
            end else if (in_frame) begin
                n_head = head_upd;
                if (i_byte == tcp_pkg::CH_EQ) begin
                    n_start = r_pos + 8'd1;
                end
                n_tail = {r_tail[tcp_pkg::TAIL_D-2:0], i_byte};
                n_pos  = r_pos + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_start <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_start <= n_start;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_valid <= (take && is_bang) || (r_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && is_bang) begin
            r_frm <= frm;
        end
    end

    assign o_valid = r_valid;
    assign o_frm   = r_frm;

endmodule

`default_nettype wire

// File: rtl/core/tcp_value_calc.sv
// ---------------------------------------------------------------------------
// tcp_value_calc
// weighted digit sums, scaling by 10000 and sign; holds the result register
// ---------------------------------------------------------------------------
`default_nettype none

module tcp_value_calc (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire tcp_pkg::t_frm                 i_frm,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output tcp_pkg::t_target                   o_target,
    output logic signed [tcp_pkg::VAL_W-1:0]   o_value
);

    logic                                   r_v2;
    logic signed [tcp_pkg::PART_W-1:0]      r_ipart;
    logic signed [tcp_pkg::PART_W-1:0]      r_fpart;
    logic                                   r_neg;
    tcp_pkg::t_target                       r_tgt2;
    logic                                   r_vo;
    tcp_pkg::t_target                       r_tgt;
    logic signed [tcp_pkg::VAL_W-1:0]       r_val;

    logic                                   out_ready;
    logic signed [tcp_pkg::PART_W-1:0]      isum;
    logic signed [tcp_pkg::PART_W-1:0]      fsum;
    logic signed [tcp_pkg::SUM_W-1:0]       mag;
    logic signed [tcp_pkg::SUM_W-1:0]       sval;

    assign out_ready = !r_vo || i_ready;
    assign o_ready   = !r_v2 || out_ready;

    always_comb begin
        isum = '0;
        fsum = '0;
        for (int j = 0; j < 4; j++) begin
            fsum = fsum + tcp_pkg::digit(i_frm.tail[j]) * tcp_pkg::pow10(2'(j));
            if (3'(j) < i_frm.int_cnt) begin
                isum = isum + tcp_pkg::digit(i_frm.tail[5 + j]) * tcp_pkg::pow10(2'(j));
            end
        end
        if (!i_frm.ok) begin
            isum = '0;
            fsum = '0;
        end
    end

    always_comb begin
        mag  = tcp_pkg::SUM_W'(r_ipart) * 34'sd10000 + tcp_pkg::SUM_W'(r_fpart);
        sval = r_neg ? -mag : mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v2 <= i_valid;
            end
            if (out_ready) begin
                r_vo <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ipart <= isum;
            r_fpart <= fsum;
            r_neg   <= i_frm.neg;
            r_tgt2  <= i_frm.target;
        end
        if (out_ready && r_v2) begin
            r_tgt <= r_tgt2;
            r_val <= sval[tcp_pkg::VAL_W-1:0];
        end
    end

    assign o_valid  = r_vo;
    assign o_target = r_tgt;
    assign o_value  = r_val;

endmodule

`default_nettype wire

// File: rtl/core/tuning_command_parser_core.sv
// ---------------------------------------------------------------------------
// tuning_command_parser_core
// parses tuning command frames KEY=[-]dddd.dddd! (one to four integer digits) into a target and a value
// ---------------------------------------------------------------------------
// input channel s_axis carries one received byte per item; output channel
// m_axis carries one result item for every end marker byte.
// a byte is taken every cycle while s_axis_tready is high; frame state updates
// on the edge that accepts the byte, so throughput is one byte per cycle.
// the edge that accepts an end marker loads the frame snapshot register; the
// item then moves to the digit sum register and on to the result register,
// where the value is scaled by 10000 and signed and m_axis_tvalid rises.
// the three result stages form an elastic pipeline: when m_axis_tready is low
// the stages fill, and s_axis_tready drops only once all three hold an item;
// from then on every byte waits, end marker or not, until a result leaves.
// synchronous reset clears the frame position, head bytes, tail window,
// value start and all stage valid flags; the next byte starts a new frame.
// ---------------------------------------------------------------------------
`default_nettype none

module tuning_command_parser_core #(
    parameter int unsigned MAX_FRAME = tcp_pkg::MAX_FRAME_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [7:0] rx_byte
    input  wire logic [tcp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [3:0] target_select, [36:4] value, [39:37] zero
    output logic [tcp_pkg::OUT_TDATA_W-1:0]          m_axis_tdata
);

    logic                                   frm_valid;
    logic                                   calc_ready;
    tcp_pkg::t_frm                          frm;
    tcp_pkg::t_target                       res_target;
    logic signed [tcp_pkg::VAL_W-1:0]       res_value;

    tcp_frame_track #(
        .MAX_FRAME (MAX_FRAME)
    ) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .o_valid (frm_valid),
        .i_ready (calc_ready),
        .o_frm   (frm)
    );

    tcp_value_calc u_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (frm_valid),
        .o_ready  (calc_ready),
        .i_frm    (frm),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_target (res_target),
        .o_value  (res_value)
    );

    assign m_axis_tdata = {3'b000, res_value, res_target};

    // an accepted end marker always lands in the snapshot register
    a_bang_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata == tcp_pkg::CH_BANG)
        |=> frm_valid)
        else $error("end marker not captured");

    // a stalled snapshot is held unchanged
    a_frm_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (frm_valid && !calc_ready) |=> (frm_valid && $stable(frm)))
        else $error("frame snapshot lost under stall");

    // input backpressure only while the snapshot register is occupied
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> frm_valid)
        else $error("input stalled with empty pipeline");

    // decoded target stays within the defined codes
    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:0] <= tcp_pkg::TGT_RES))
        else $error("target code out of range");

endmodule

`default_nettype wire
